// ===== rtl/core/clcd_pkg.sv =====
package clcd_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_SET_POS = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;
    localparam logic [1:0] REQ_SERVICE = 2'd3;

    // LCD command codes carried in cmd_kind
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LOCATE = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    // Cell layout: dirty mark on top, 7-bit character below
    localparam logic [7:0] BLANK_CELL = 8'hA0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [7:0] row;
        logic [7:0] col;
        logic       lcd_accepts;
    } t_in_word;

    typedef struct packed {
        logic [1:0] cmd_kind;
        logic [6:0] cmd_index;
        logic [6:0] cmd_char;
        logic [6:0] pending_count;
        logic       lcd_rejected;
    } t_out_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;
        logic clr_start;
        logic clr_step;
        logic char_rd;
        logic char_wr;
        logic set_pos;
        logic settle;
        logic scan_step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sweep_last;
        logic cell_dirty;
    } t_dp_stat;

endpackage

// ===== rtl/core/clcd_dp.sv =====
module clcd_dp #(
    parameter int ROWS = 4,
    parameter int COLS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clcd_pkg::t_dp_cmd   i_cmd,
    input  clcd_pkg::t_in_word  i_word,
    output clcd_pkg::t_dp_stat  o_stat,
    output clcd_pkg::t_out_word o_word
);
    import clcd_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DW    = $clog2(CELLS + 1);
    localparam int PW    = 9 + $clog2(COLS);

    localparam logic [IW-1:0] LAST_CELL = IW'(CELLS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
    localparam logic [DW-1:0] FULL      = DW'(CELLS);
    localparam logic [PW-1:0] CELLS_P   = PW'(CELLS);
    localparam logic [PW-1:0] COLS_P    = PW'(COLS);

    typedef enum logic [2:0] {
        PH_SCAN     = 3'b001,
        PH_LOCATE   = 3'b010,
        PH_TRANSMIT = 3'b100
    } t_phase;

    // Cell memory and its registered read data
    logic [7:0]    r_mem [CELLS];
    logic [7:0]    r_rd;
    logic          w_en;
    logic [IW-1:0] w_addr;
    logic [7:0]    w_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    t_in_word      r_req;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [IW-1:0] r_scan_idx, n_scan_idx;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [IW-1:0] r_sweep, n_sweep;
    logic          r_synced, n_synced;
    t_phase        r_phase, n_phase;
    logic [DW-1:0] r_dirty, n_dirty;

    logic [1:0]    r_kind, n_kind;
    logic [IW-1:0] r_cidx, n_cidx;
    logic [6:0]    r_cchr, n_cchr;
    logic          r_rej, n_rej;
    t_out_word     r_out, n_out;

    logic [IW-1:0] a_idx;
    logic [CW-1:0] a_col;
    logic          a_eol;
    logic [IW-1:0] s_idx;
    logic [CW-1:0] s_col;
    logic          s_synced;
    logic [PW-1:0] pos;

    // Scan position one cell on, row-major with wrap
    assign a_eol = (r_scan_col == LAST_COL);
    assign a_col = a_eol ? '0 : r_scan_col + 1'b1;
    assign a_idx = (r_scan_idx == LAST_CELL) ? '0 : r_scan_idx + 1'b1;

    // Settle the phase left by the previous service step
    always_comb begin
        s_idx    = r_scan_idx;
        s_col    = r_scan_col;
        s_synced = r_synced;
        unique case (r_phase)
            PH_LOCATE: begin
                s_synced = 1'b1;
            end
            PH_TRANSMIT: begin
                s_idx = a_idx;
                s_col = a_col;
                if (a_eol) begin
                    s_synced = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign pos = PW'(r_req.row) * COLS_P + PW'(r_req.col);

    always_comb begin
        n_cursor   = r_cursor;
        n_scan_idx = r_scan_idx;
        n_scan_col = r_scan_col;
        n_sweep    = r_sweep;
        n_synced   = r_synced;
        n_phase    = r_phase;
        n_dirty    = r_dirty;
        n_kind     = r_kind;
        n_cidx     = r_cidx;
        n_cchr     = r_cchr;
        n_rej      = r_rej;
        n_out      = r_out;
        w_en       = 1'b0;
        w_addr     = r_cursor;
        w_data     = r_rd;
        rd_en      = 1'b0;
        rd_addr    = r_cursor;

        // Start of an item: no command unless the scan finds one
        if (i_cmd.load_req) begin
            n_kind = KIND_NONE;
            n_cidx = '0;
            n_cchr = '0;
            n_rej  = 1'b0;
        end

        if (i_cmd.clr_start) begin
            n_sweep  = '0;
            n_dirty  = FULL;
            n_cursor = '0;
        end

        // Blank one cell per cycle
        if (i_cmd.clr_step) begin
            w_en    = 1'b1;
            w_addr  = r_sweep;
            w_data  = BLANK_CELL;
            n_sweep = (r_sweep == LAST_CELL) ? '0 : r_sweep + 1'b1;
        end

        if (i_cmd.char_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_cursor;
        end

        // Store only a changed character and count a newly dirty cell
        if (i_cmd.char_wr) begin
            if (r_rd[6:0] != r_req.char_code[6:0]) begin
                w_en   = 1'b1;
                w_addr = r_cursor;
                w_data = {1'b1, r_req.char_code[6:0]};
                if (!r_rd[7] && (r_dirty < FULL)) begin
                    n_dirty = r_dirty + 1'b1;
                end
            end
            n_cursor = (r_cursor == LAST_CELL) ? '0 : r_cursor + 1'b1;
        end

        if (i_cmd.set_pos) begin
            n_cursor = (pos < CELLS_P) ? pos[IW-1:0] : '0;
        end

        if (i_cmd.settle) begin
            n_scan_idx = s_idx;
            n_scan_col = s_col;
            n_synced   = s_synced;
            n_phase    = PH_SCAN;
            rd_en      = 1'b1;
            rd_addr    = s_idx;
        end

        // Examine the cell just read: issue a command or move on
        if (i_cmd.scan_step) begin
            if (r_rd[7]) begin
                if (!r_req.lcd_accepts) begin
                    n_rej = 1'b1;
                end else if (!r_synced) begin
                    n_kind  = KIND_LOCATE;
                    n_cidx  = r_scan_idx;
                    n_phase = PH_LOCATE;
                end else begin
                    n_kind  = KIND_WRITE;
                    n_cchr  = r_rd[6:0];
                    w_en    = 1'b1;
                    w_addr  = r_scan_idx;
                    w_data  = {1'b0, r_rd[6:0]};
                    n_dirty = (r_dirty != '0) ? r_dirty - 1'b1 : '0;
                    n_phase = PH_TRANSMIT;
                end
            end else begin
                n_synced   = 1'b0;
                n_scan_idx = a_idx;
                n_scan_col = a_col;
                rd_en      = 1'b1;
                rd_addr    = a_idx;
            end
        end

        if (i_cmd.emit) begin
            n_out.cmd_kind      = r_kind;
            n_out.cmd_index     = 7'(r_cidx);
            n_out.cmd_char      = r_cchr;
            n_out.pending_count = 7'(r_dirty);
            n_out.lcd_rejected  = r_rej;
        end
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_word;
        end
        r_kind <= n_kind;
        r_cidx <= n_cidx;
        r_cchr <= n_cchr;
        r_rej  <= n_rej;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_scan_idx <= '0;
            r_scan_col <= '0;
            r_sweep    <= '0;
            r_synced   <= 1'b0;
            r_phase    <= PH_SCAN;
            r_dirty    <= FULL;
        end else begin
            r_cursor   <= n_cursor;
            r_scan_idx <= n_scan_idx;
            r_scan_col <= n_scan_col;
            r_sweep    <= n_sweep;
            r_synced   <= n_synced;
            r_phase    <= n_phase;
            r_dirty    <= n_dirty;
        end
    end

    assign o_stat.sweep_last = (r_sweep == LAST_CELL);
    assign o_stat.cell_dirty = r_rd[7];
    assign o_word            = r_out;

endmodule

// ===== rtl/core/clcd_ctrl.sv =====
module clcd_ctrl #(
    parameter int LOOKAHEAD = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    output logic               o_valid,
    input  logic               i_stall,
    input  clcd_pkg::t_dp_stat i_stat,
    output clcd_pkg::t_dp_cmd  o_cmd
);
    import clcd_pkg::*;

    localparam int LW = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
    localparam logic [LW-1:0] LAST_LOOK = LW'(LOOKAHEAD - 1);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_CHAR_RD = 8'b0000_0100,
        S_CHAR_WR = 8'b0000_1000,
        S_POS     = 8'b0001_0000,
        S_SETTLE  = 8'b0010_0000,
        S_SCAN    = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_look, n_look;
    logic          r_emit_after, n_emit_after;
    logic          r_out_valid, n_out_valid;
    logic          out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_look       = r_look;
        n_emit_after = r_emit_after;
        o_cmd        = '0;
        unique case (r_state)
            // Blank the store, after reset or for a clear request
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = r_emit_after ? S_EMIT : S_IDLE;
                end
            end
            // Take a word and dispatch on its request
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    unique case (i_req_type)
                        REQ_WRITE:   n_state = S_CHAR_RD;
                        REQ_SET_POS: n_state = S_POS;
                        REQ_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_emit_after    = 1'b1;
                            n_state         = S_CLEAR;
                        end
                        REQ_SERVICE: n_state = S_SETTLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_CHAR_RD: begin
                o_cmd.char_rd = 1'b1;
                n_state       = S_CHAR_WR;
            end
            S_CHAR_WR: begin
                o_cmd.char_wr = 1'b1;
                n_state       = S_EMIT;
            end
            S_POS: begin
                o_cmd.set_pos = 1'b1;
                n_state       = S_EMIT;
            end
            S_SETTLE: begin
                o_cmd.settle = 1'b1;
                n_look       = '0;
                n_state      = S_SCAN;
            end
            // One cell per cycle until a dirty one or the lookahead runs out
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.cell_dirty || (r_look == LAST_LOOK)) begin
                    n_state = S_EMIT;
                end else begin
                    n_look = r_look + 1'b1;
                end
            end
            // Hold until the output register is free
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.emit | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_look       <= '0;
            r_emit_after <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_look       <= n_look;
            r_emit_after <= n_emit_after;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/char_lcd_dirty_refresh.sv =====
// Channel   Valid     Stall     Payload   Word
// input     i_valid   o_stall   i_word    one request
// output    o_valid   i_stall   o_word    one result per request
//
// Each accepted word yields one result: a service step examines 1 to LOOKAHEAD
// cells, and a clear first blanks all ROWS*COLS cells.
// The cell memory, one read port, sets the pace: one cell is examined a cycle.
// After reset a blanking pass runs with o_stall high.
// A held result does not block the next request; that request waits at the
// end of its work until the output register frees.
module char_lcd_dirty_refresh #(
    parameter int ROWS      = 4,
    parameter int COLS      = 20,
    parameter int LOOKAHEAD = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  clcd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output clcd_pkg::t_out_word o_word
);
    import clcd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    clcd_ctrl #(
        .LOOKAHEAD(LOOKAHEAD)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_word.req_type),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    clcd_dp #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_word  (i_word),
        .o_stat  (dp_stat),
        .o_word  (o_word)
    );

endmodule

// ===== rtl/core/clcd_chk.sv =====
module clcd_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input clcd_pkg::t_out_word o_word
);
    import clcd_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_owed;

    assign in_acc  = i_valid & !o_stall;
    assign out_acc = o_valid & !i_stall;

    // Count words taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else begin
            r_owed <= r_owed + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("held result changed or dropped");

    a_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_owed != 2'd0)
        else $error("result shown with no request outstanding");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed == 2'd2 |-> o_stall)
        else $error("third request taken while two are owed");

    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.lcd_rejected |-> o_word.cmd_kind == KIND_NONE)
        else $error("refused command still reported as issued");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.cmd_kind != KIND_WRITE |-> o_word.cmd_char == 7'd0)
        else $error("character shown without a write command");

endmodule

bind char_lcd_dirty_refresh clcd_chk u_clcd_chk (.*);

// ===== tb/sv/tb_char_lcd_dirty_refresh.sv =====
`timescale 1ns / 100ps

module tb_char_lcd_dirty_refresh;

    import clcd_pkg::*;

    localparam int ROWS      = 4;
    localparam int COLS      = 20;
    localparam int LOOKAHEAD = 8;
    localparam int CELLS     = ROWS * COLS;
    localparam int N_RANDOM  = 880;
    localparam int CALM_TAIL = 120;
    localparam int LIMIT     = 600000;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_LOCATE,
        PH_TRANSMIT
    } t_refresh_phase;

    // One directed row: request word, and the result typed in where obvious
    typedef struct packed {
        t_in_word  req;
        logic      typed;
        t_out_word want;
    } t_stim_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_word  i_word  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_word;

    // Shadow of the frame buffer and the refresh walker
    logic [7:0]     shadow_cells [CELLS];
    int             wr_cursor;
    int             scan_r;
    int             scan_c;
    bit             lcd_in_sync;
    t_refresh_phase walk_phase;
    int             dirty_cnt;

    t_out_word due_cmds [$];
    t_stim_row stim_tab [$];
    int        mism_cnt  = 0;
    int        cyc_cnt   = 0;
    bit        calm      = 1'b0;
    int        gap_pct   = 10;
    int        stall_pct = 10;

    char_lcd_dirty_refresh #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .LOOKAHEAD (LOOKAHEAD)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung block
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt == LIMIT) begin
            $display("[char_lcd_dirty_refresh] ERROR");
            $finish;
        end
    end

    function automatic void blank_frame();
        for (int k = 0; k < CELLS; k++) begin
            shadow_cells[k] = BLANK_CELL;
        end
        dirty_cnt = CELLS;
    endfunction

    // Move the scan position on by one cell, wrapping by line and by frame
    function automatic void step_scan(bit drop_at_eol);
        scan_c++;
        if (scan_c >= COLS) begin
            scan_c = 0;
            if (drop_at_eol) begin
                lcd_in_sync = 1'b0;
            end
            scan_r++;
            if (scan_r >= ROWS) begin
                scan_r = 0;
            end
        end
    endfunction

    // Apply one request to the shadow and return the command it yields
    function automatic t_out_word predict_refresh(t_in_word w);
        t_out_word  r;
        logic [6:0] ch;
        int         pos;
        int         idx;
        bit         hit;
        r   = '0;
        ch  = w.char_code[6:0];
        idx = 0;
        hit = 1'b0;
        case (w.req_type)
            REQ_WRITE: begin
                if (shadow_cells[wr_cursor][6:0] != ch) begin
                    if (!shadow_cells[wr_cursor][7] && dirty_cnt < CELLS) begin
                        dirty_cnt++;
                    end
                    shadow_cells[wr_cursor] = {1'b1, ch};
                end
                wr_cursor = (wr_cursor + 1 >= CELLS) ? 0 : wr_cursor + 1;
            end
            REQ_SET_POS: begin
                pos       = int'(w.row) * COLS + int'(w.col);
                wr_cursor = (pos >= CELLS) ? 0 : pos;
            end
            REQ_CLEAR: begin
                blank_frame();
                wr_cursor = 0;
            end
            default: begin
                // settle the previous command before looking ahead
                if (walk_phase == PH_LOCATE) begin
                    lcd_in_sync = 1'b1;
                end else if (walk_phase == PH_TRANSMIT) begin
                    step_scan(1'b1);
                end
                walk_phase = PH_SCAN;
                for (int n = 0; n < LOOKAHEAD && !hit; n++) begin
                    idx = scan_r * COLS + scan_c;
                    if (idx >= CELLS) begin
                        idx = 0;
                    end
                    if (shadow_cells[idx][7]) begin
                        hit = 1'b1;
                    end else begin
                        lcd_in_sync = 1'b0;
                        step_scan(1'b0);
                    end
                end
                if (hit && !w.lcd_accepts) begin
                    r.lcd_rejected = 1'b1;
                end else if (hit && !lcd_in_sync) begin
                    r.cmd_kind  = KIND_LOCATE;
                    r.cmd_index = 7'(idx);
                    walk_phase  = PH_LOCATE;
                end else if (hit) begin
                    r.cmd_kind        = KIND_WRITE;
                    r.cmd_char        = shadow_cells[idx][6:0];
                    shadow_cells[idx] = {1'b0, shadow_cells[idx][6:0]};
                    if (dirty_cnt > 0) begin
                        dirty_cnt--;
                    end
                    walk_phase = PH_TRANSMIT;
                end
            end
        endcase
        r.pending_count = 7'(dirty_cnt);
        return r;
    endfunction

    // Random request, biased towards refresh traffic with a given share
    function automatic t_in_word roll_request(int svc_pct);
        t_in_word w;
        int       pick;
        w.req_type    = REQ_SERVICE;
        w.char_code   = 8'($urandom);
        w.row         = 8'($urandom);
        w.col         = 8'($urandom);
        w.lcd_accepts = ($urandom_range(0, 99) < 85);
        pick          = $urandom_range(0, 99);
        if (pick >= svc_pct) begin
            pick = $urandom_range(0, 99);
            if (pick < 64) begin
                w.req_type = REQ_WRITE;
                // rewrite the held character half the time
                if ($urandom_range(0, 1)) begin
                    w.char_code = {1'($urandom), shadow_cells[wr_cursor][6:0]};
                end
            end else if (pick < 94) begin
                w.req_type = REQ_SET_POS;
                if ($urandom_range(0, 3) != 0) begin
                    w.row = 8'($urandom_range(0, ROWS - 1));
                    w.col = 8'($urandom_range(0, COLS - 1));
                end
            end else begin
                w.req_type = REQ_CLEAR;
            end
        end
        return w;
    endfunction

    // Hold the word until accepted, then log what it should produce
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word p;
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        p = predict_refresh(w);
        due_cmds.push_back(typed ? want : p);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Stall the result channel in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_cmds.size() == 0) begin
                $error("result word with nothing expected: %h", o_word);
                mism_cnt++;
            end else begin
                want = due_cmds.pop_front();
                if (o_word.cmd_kind !== want.cmd_kind) begin
                    $error("cmd_kind: expected %0d, got %0d", want.cmd_kind, o_word.cmd_kind);
                    mism_cnt++;
                end
                if (o_word.cmd_index !== want.cmd_index) begin
                    $error("cmd_index: expected %0d, got %0d",
                           want.cmd_index, o_word.cmd_index);
                    mism_cnt++;
                end
                if (o_word.cmd_char !== want.cmd_char) begin
                    $error("cmd_char: expected %h, got %h", want.cmd_char, o_word.cmd_char);
                    mism_cnt++;
                end
                if (o_word.pending_count !== want.pending_count) begin
                    $error("pending_count: expected %0d, got %0d",
                           want.pending_count, o_word.pending_count);
                    mism_cnt++;
                end
                if (o_word.lcd_rejected !== want.lcd_rejected) begin
                    $error("lcd_rejected: expected %0d, got %0d",
                           want.lcd_rejected, o_word.lcd_rejected);
                    mism_cnt++;
                end
            end
        end
    end

    initial begin
        blank_frame();
        wr_cursor   = 0;
        scan_r      = 0;
        scan_c      = 0;
        lcd_in_sync = 1'b0;
        walk_phase  = PH_SCAN;

        // refresh walk from reset: refuse, locate, settle, then write cell 0
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd80, 1'b1}});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1,
                            t_out_word'{KIND_LOCATE, 7'd0, 7'h00, 7'd80, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd80, 1'b1}});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1,
                            t_out_word'{KIND_WRITE, 7'd0, 7'h20, 7'd79, 1'b0}});
        // same character leaves the clean cell alone; top bit is dropped
        stim_tab.push_back({t_in_word'{REQ_WRITE, 8'h20, 8'h00, 8'h00, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        // cursor moves: off screen, last cell, wrap on write
        stim_tab.push_back({t_in_word'{REQ_SET_POS, 8'h00, 8'hFF, 8'hFF, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_SET_POS, 8'h00, 8'd3, 8'd19, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_SET_POS, 8'h00, 8'd4, 8'd0, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd79, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_WRITE, 8'h80, 8'h00, 8'h00, 1'b0}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd80, 1'b0}});
        stim_tab.push_back({t_in_word'{REQ_SET_POS, 8'h00, 8'd0, 8'd79, 1'b0}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1,
                            t_out_word'{KIND_NONE, 7'd0, 7'h00, 7'd80, 1'b0}});
        // clear keeps the walker where it was
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_SET_POS, 8'h00, 8'd3, 8'd20, 1'b0}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_WRITE, 8'h41, 8'h00, 8'h00, 1'b0}, 1'b0,
                            t_out_word'('0)});
        stim_tab.push_back({t_in_word'{REQ_SERVICE, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0,
                            t_out_word'('0)});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (stim_tab[k]) begin
            maybe_gap();
            send_word(stim_tab[k].req, stim_tab[k].typed, stim_tab[k].want);
        end

        // hold off until the block has drained
        i_valid <= 1'b0;
        while (due_cmds.size() != 0) @(posedge i_clk);

        // random traffic: vary mix and idling in blocks of 100 words
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) begin
                gap_pct   = 15 * $urandom_range(0, 2);
                stall_pct = 10 * $urandom_range(0, 2);
            end
            if (k == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (due_cmds.size() != 0) @(posedge i_clk);
            end
            calm = (k >= N_RANDOM - CALM_TAIL);
            maybe_gap();
            send_word(roll_request(((k / 100) % 2) ? 85 : 50), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (due_cmds.size() != 0) @(posedge i_clk);
        repeat (CELLS + 20) @(posedge i_clk);

        if (mism_cnt == 0) begin
            $display("[char_lcd_dirty_refresh] OK");
        end else begin
            $display("[char_lcd_dirty_refresh] ERROR");
        end
        $finish;
    end

endmodule
